// ===== rtl/core/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and constants of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
package cau_pkg;
    localparam int unsigned W = 32;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]   mode;
        logic         last;
        logic [W-1:0] re;
        logic [W-1:0] im;
        logic [W-1:0] den;
    } pre_t;
endpackage
`default_nettype wire

// ===== rtl/core/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// Two-stage front end: partial products, then sums, differences and |b|^2.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [1:0]              mode,
    input  wire logic                    last_in,
    input  wire logic [cau_pkg::W-1:0]   a_re,
    input  wire logic [cau_pkg::W-1:0]   a_im,
    input  wire logic [cau_pkg::W-1:0]   b_re,
    input  wire logic [cau_pkg::W-1:0]   b_im,
    output logic                         out_valid,
    output cau_pkg::pre_t                out_data
);
    logic [cau_pkg::W-1:0] arbr_reg, aibi_reg, arbi_reg, aibr_reg, brbr_reg, bibi_reg;
    logic [cau_pkg::W-1:0] sre_reg, sim_reg;
    logic [1:0]            mode_reg;
    logic                  last_reg, v1_reg;
    cau_pkg::pre_t         pre_next, pre_reg;
    logic                  v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arbr_reg <= cau_pkg::W'(a_re * b_re);
            aibi_reg <= cau_pkg::W'(a_im * b_im);
            arbi_reg <= cau_pkg::W'(a_re * b_im);
            aibr_reg <= cau_pkg::W'(a_im * b_re);
            brbr_reg <= cau_pkg::W'(b_re * b_re);
            bibi_reg <= cau_pkg::W'(b_im * b_im);
            sre_reg  <= (mode == cau_pkg::MODE_SUB) ? a_re - b_re : a_re + b_re;
            sim_reg  <= (mode == cau_pkg::MODE_SUB) ? a_im - b_im : a_im + b_im;
            mode_reg <= mode;
            last_reg <= last_in;
            pre_reg  <= pre_next;
        end
    end

    always_comb
    begin
        pre_next.mode = mode_reg;
        pre_next.last = last_reg;
        pre_next.den  = brbr_reg + bibi_reg;
        case (mode_reg)
            cau_pkg::MODE_MUL:
            begin
                pre_next.re = arbr_reg - aibi_reg;
                pre_next.im = arbi_reg + aibr_reg;
            end
            cau_pkg::MODE_DIV:
            begin
                pre_next.re = arbr_reg + aibi_reg;
                pre_next.im = aibr_reg - arbi_reg;
            end
            default:
            begin
                pre_next.re = sre_reg;
                pre_next.im = sim_reg;
            end
        endcase
    end

    assign out_valid = v2_reg;
    assign out_data  = pre_reg;
endmodule
`default_nettype wire

// ===== rtl/core/cau_div.sv =====
// ----------------------------------------------------------------------------
// cau_div
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_div (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire cau_pkg::pre_t          in_data,
    output logic                        out_valid,
    output logic [cau_pkg::W-1:0]       c_re,
    output logic [cau_pkg::W-1:0]       c_im,
    output logic                        zero_divisor,
    output logic                        last_out
);
    localparam int unsigned W = cau_pkg::W;
    localparam int unsigned S = W + 1;

    typedef struct packed {
        logic [1:0]   mode;
        logic         last;
        logic         zd;
        logic         nre;
        logic         nim;
        logic [W-1:0] rre;
        logic [W-1:0] rim;
        logic [W-1:0] qre;
        logic [W-1:0] qim;
        logic [W-1:0] d;
    } st_t;

    st_t          st_reg [S];
    st_t          st_next [S];
    logic [S-1:0] v_reg;

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        mag = x[W-1] ? W'(-x) : x;
    endfunction

    always_comb
    begin
        st_next[0].mode = in_data.mode;
        st_next[0].last = in_data.last;
        st_next[0].zd   = (in_data.den == '0);
        st_next[0].nre  = in_data.re[W-1] ^ in_data.den[W-1];
        st_next[0].nim  = in_data.im[W-1] ^ in_data.den[W-1];
        st_next[0].rre  = '0;
        st_next[0].rim  = '0;
        st_next[0].qre  = (in_data.mode == cau_pkg::MODE_DIV) ? mag(in_data.re) : in_data.re;
        st_next[0].qim  = (in_data.mode == cau_pkg::MODE_DIV) ? mag(in_data.im) : in_data.im;
        st_next[0].d    = mag(in_data.den);
    end

    for (genvar k = 1; k < S; k++)
    begin : g_stage
        logic [W:0] tre, tim;
        always_comb
        begin
            st_next[k] = st_reg[k-1];
            if (st_reg[k-1].mode == cau_pkg::MODE_DIV)
            begin
                tre = {st_reg[k-1].rre, st_reg[k-1].qre[W-1]};
                tim = {st_reg[k-1].rim, st_reg[k-1].qim[W-1]};
                st_next[k].qre = {st_reg[k-1].qre[W-2:0], 1'b0};
                st_next[k].qim = {st_reg[k-1].qim[W-2:0], 1'b0};
                if (tre >= {1'b0, st_reg[k-1].d})
                begin
                    tre = tre - {1'b0, st_reg[k-1].d};
                    st_next[k].qre[0] = 1'b1;
                end
                if (tim >= {1'b0, st_reg[k-1].d})
                begin
                    tim = tim - {1'b0, st_reg[k-1].d};
                    st_next[k].qim[0] = 1'b1;
                end
                st_next[k].rre = tre[W-1:0];
                st_next[k].rim = tim[W-1:0];
            end
            else
            begin
                tre = '0;
                tim = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[S-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < S; i++)
                st_reg[i] <= st_next[i];
        end
    end

    always_comb
    begin
        c_re         = st_reg[S-1].qre;
        c_im         = st_reg[S-1].qim;
        zero_divisor = 1'b0;
        if (st_reg[S-1].mode == cau_pkg::MODE_DIV)
        begin
            if (st_reg[S-1].zd)
            begin
                c_re         = '0;
                c_im         = '0;
                zero_divisor = 1'b1;
            end
            else
            begin
                c_re = st_reg[S-1].nre ? W'(-st_reg[S-1].qre) : st_reg[S-1].qre;
                c_im = st_reg[S-1].nim ? W'(-st_reg[S-1].qim) : st_reg[S-1].qim;
            end
        end
    end

    assign last_out  = st_reg[S-1].last;
    assign out_valid = v_reg[S-1];
endmodule
`default_nettype wire

// ===== rtl/core/complex_arith_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arith_unit
// Streaming complex add, subtract, multiply and divide.
// ----------------------------------------------------------------------------
// One request enters per cycle while s_axis_tready is high. The pipe holds two
// front stages, 33 divider stages made of an entry register and 32 one-bit
// stages, and one output register. The whole pipe advances when the output
// register is free or being taken, so throughput is one result per cycle
// whenever the sink keeps m_axis_tready high.
`default_nettype none
module complex_arith_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // a_re, a_im, b_re, b_im
    input  wire logic [1:0]   s_axis_tuser,  // mode
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [63:0]       m_axis_tdata,  // c_re, c_im
    output logic              m_axis_tuser,  // zero_divisor
    output logic              m_axis_tlast
);
    localparam int unsigned W = cau_pkg::W;

    logic          en, fv, dv, zd, lo;
    cau_pkg::pre_t pre;
    logic [W-1:0]  cre, cim;
    logic          ov_reg;
    logic [2*W-1:0] od_reg;
    logic          oz_reg, ol_reg;

    assign en = !ov_reg || m_axis_tready;
    assign s_axis_tready = en;

    cau_front u_front (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_axis_tvalid),
        .mode(s_axis_tuser), .last_in(s_axis_tlast),
        .a_re(s_axis_tdata[31:0]), .a_im(s_axis_tdata[63:32]),
        .b_re(s_axis_tdata[95:64]), .b_im(s_axis_tdata[127:96]),
        .out_valid(fv), .out_data(pre)
    );

    cau_div u_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(fv), .in_data(pre),
        .out_valid(dv), .c_re(cre), .c_im(cim),
        .zero_divisor(zd), .last_out(lo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= dv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            od_reg <= {cim, cre};
            oz_reg <= zd;
            ol_reg <= lo;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = oz_reg;
    assign m_axis_tlast  = ol_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_zflag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("zero divisor with nonzero result");
endmodule
`default_nettype wire

// ===== dv/cau_checker.sv =====
// ----------------------------------------------------------------------------
// cau_checker
// Watches both stream channels of the complex arithmetic unit, computes the
// expected complex result of every accepted request and compares it with the
// results in order.
// ----------------------------------------------------------------------------
module cau_checker (
    input  logic         clk,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [63:0]  m_axis_tdata,
    input  logic         m_axis_tuser,
    input  logic         m_axis_tlast,
    output int           errors,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] c_re;
        logic [31:0] c_im;
        logic        zero_div;
        logic        last;
    } cplx_res_t;

    cplx_res_t expected_q[$];

    initial errors = 0;
    initial pending = 0;

    function automatic logic signed [31:0] quot_trunc(logic signed [31:0] n,
                                                      logic signed [31:0] d);
        logic [31:0] mn;
        logic [31:0] md;
        logic [31:0] q;
        mn = n[31] ? -n : n;
        md = d[31] ? -d : d;
        q = mn / md;
        if (n[31] != d[31])
            q = -q;
        return q;
    endfunction

    function automatic cplx_res_t complex_result(logic [1:0] op, logic [127:0] d,
                                                 logic lst);
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] br;
        logic signed [31:0] bi;
        logic signed [31:0] den;
        cplx_res_t r;
        ar = d[31:0];
        ai = d[63:32];
        br = d[95:64];
        bi = d[127:96];
        r = '0;
        r.last = lst;
        case (cau_pkg::mode_t'(op))
            cau_pkg::MODE_ADD:
            begin
                r.c_re = ar + br;
                r.c_im = ai + bi;
            end
            cau_pkg::MODE_SUB:
            begin
                r.c_re = ar - br;
                r.c_im = ai - bi;
            end
            cau_pkg::MODE_MUL:
            begin
                r.c_re = ar * br - ai * bi;
                r.c_im = ar * bi + ai * br;
            end
            default:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    r.zero_div = 1'b1;
                else
                begin
                    r.c_re = quot_trunc(ar * br + ai * bi, den);
                    r.c_im = quot_trunc(ai * br - ar * bi, den);
                end
            end
        endcase
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cplx_res_t w;
        if (s_axis_tvalid && s_axis_tready)
            expected_q.push_back(complex_result(s_axis_tuser, s_axis_tdata, s_axis_tlast));
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
                report("unexpected result", m_axis_tdata[31:0], '0);
            else
            begin
                w = expected_q.pop_front();
                if (m_axis_tdata[31:0] !== w.c_re)
                    report("c_re", m_axis_tdata[31:0], w.c_re);
                if (m_axis_tdata[63:32] !== w.c_im)
                    report("c_im", m_axis_tdata[63:32], w.c_im);
                if (m_axis_tuser !== w.zero_div)
                    report("zero_divisor", 32'(m_axis_tuser), 32'(w.zero_div));
                if (m_axis_tlast !== w.last)
                    report("last", 32'(m_axis_tlast), 32'(w.last));
            end
        end
        pending = expected_q.size();
    end
endmodule

// ===== dv/tb_complex_arith_unit.sv =====
// ----------------------------------------------------------------------------
// tb_complex_arith_unit
// Drives directed and random complex requests of all four operations with
// random gaps on both sides and a long output stall, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_complex_arith_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 36;
    localparam int NUM_RANDOM = 1800;
    localparam longint CYCLE_LIMIT = 200000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    int           errors;
    int           pending;
    longint       cycles;
    bit           hold_sink;
    bit           sent_all;

    complex_arith_unit dut (.*);

    cau_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return '0;
            4, 5: return $urandom_range(0, 40) - 20;
            6: return $urandom_range(0, 131071) - 65536;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(cau_pkg::mode_t op, logic [31:0] ar, logic [31:0] ai,
                                logic [31:0] br, logic [31:0] bi, logic lst,
                                int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {bi, br, ai, ar};
        s_axis_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    initial
    begin
        int g;
        hold_sink = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_sink)
            begin
                m_axis_tready <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                g = $urandom_range(0, 7);
                if (!sent_all && cycles % 400 < 100)
                    g = 0;
                if (g != 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
                m_axis_tready <= 1'b1;
                do
                    @(posedge clk);
                while (!m_axis_tvalid && !hold_sink);
            end
        end
    end

    initial
    begin
        cau_pkg::mode_t op;
        int gap;
        logic [31:0] ar;
        logic [31:0] ai;
        logic [31:0] br;
        logic [31:0] bi;
        sent_all = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = cau_pkg::MODE_ADD;
        s_axis_tlast = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(cau_pkg::MODE_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h1,
                     32'hffff_ffff, 1'b0, 0);
        send_request(cau_pkg::MODE_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h1,
                     32'hffff_ffff, 1'b0, 0);
        send_request(cau_pkg::MODE_MUL, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                     32'h7fff_ffff, 1'b0, 0);
        send_request(cau_pkg::MODE_MUL, 3, -4, 5, 6, 1'b1, 0);
        send_request(cau_pkg::MODE_DIV, 7, 8, 0, 0, 1'b0, 0);
        send_request(cau_pkg::MODE_DIV, 7, 8, 32'h0001_0000, 0, 1'b0, 0);
        send_request(cau_pkg::MODE_DIV, 7, 8, 32'h0001_0000, 32'h0001_0000, 1'b0, 1);
        send_request(cau_pkg::MODE_DIV, 32'h8000_0000, 0, 32'hffff_ffff, 0, 1'b0, 0);
        send_request(cau_pkg::MODE_DIV, 32'h8000_0000, 32'h8000_0000, 1, 0, 1'b0, 0);
        send_request(cau_pkg::MODE_DIV, -100, 37, 3, -2, 1'b0, 2);
        send_request(cau_pkg::MODE_DIV, 100, -37, -3, 2, 1'b1, 0);
        send_request(cau_pkg::MODE_DIV, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff,
                     32'h7fff_ffff, 1'b0, 0);
        send_request(cau_pkg::MODE_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                     32'hffff_ffff, 1'b1, 0);
        send_request(cau_pkg::MODE_ADD, 0, 0, 0, 0, 1'b0, 0);

        fork
            begin
                wait (cycles > 800);
                hold_sink = 1'b1;
                repeat (300) @(posedge clk);
                hold_sink = 1'b0;
            end
        join_none

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            op = cau_pkg::mode_t'($urandom_range(0, 3));
            ar = pick_value();
            ai = pick_value();
            br = pick_value();
            bi = pick_value();
            if (op == cau_pkg::MODE_DIV && $urandom_range(0, 9) == 0)
            begin
                br = '0;
                bi = '0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (i % 200 < 40)
                gap = 0;
            send_request(op, ar, ai, br, bi, $urandom_range(0, 7) == 0, gap);
        end
        s_axis_tvalid <= 1'b0;
        sent_all = 1'b1;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/cau_pkg.sv
rtl/core/cau_front.sv
rtl/core/cau_div.sv
rtl/core/complex_arith_unit.sv
dv/cau_checker.sv
dv/tb_complex_arith_unit.sv
